### rtl/core/bpra_pkg.sv
// Package for the bitmap page run allocator: constants, register indexes, sequencer states.
`default_nettype none

package bpra_pkg;

    localparam int MAX_PAGES_DEF  = 4096;
    localparam int PAGE_SHIFT_DEF = 12;

    localparam int COUNT_W    = 13;
    localparam int ADDR_W     = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 16;

    localparam int ROW_BITS   = 8;
    localparam int ROW_SEL_W  = 3;

    localparam logic [ADDR_W-1:0]  BASE_RESET = 32'hC010_0000;
    localparam logic [COUNT_W-1:0] POOL_RESET = 13'd4096;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_PAGES   = 8'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

### rtl/core/bitmap_page_run_allocator_unit.sv
// First-fit page run allocator over a one-bit-per-page occupancy map held in a row memory.
// A rejected count goes straight to the response; else the scan reads one 8-page map row
//   per cycle to the run or the pool end, then reads and rewrites each map row of the run.
// Throughput: one item at a time; s_tready is high only between items.
// Reset: synchronous, active low; a clearing pass then zeroes every map row, with s_tready
//   low meanwhile.
`default_nettype none

module bitmap_page_run_allocator_unit #(
    parameter int MAX_PAGES  = bpra_pkg::MAX_PAGES_DEF,
    parameter int PAGE_SHIFT = bpra_pkg::PAGE_SHIFT_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,

    input  wire                                 cfg_wr_en,
    input  wire  [bpra_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  wire  [bpra_pkg::CFG_DATA_W-1:0]     cfg_wr_data,

    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [bpra_pkg::S_TDATA_W-1:0]      s_tdata,   // [12:0] page_count

    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [bpra_pkg::ADDR_W-1:0]         m_tdata,   // [31:0] start_address
    output logic                                m_tuser    // [0] granted
);

    localparam int ROWS_MIN  = (MAX_PAGES + bpra_pkg::ROW_BITS - 1) / bpra_pkg::ROW_BITS;
    localparam int ROW_AW    = ($clog2(ROWS_MIN) < 1) ? 1 : $clog2(ROWS_MIN);
    localparam int ROW_DEPTH = 1 << ROW_AW;
    localparam int PAGE_AW   = ROW_AW + bpra_pkg::ROW_SEL_W;
    localparam int LIM_W     = PAGE_AW + 1;
    localparam int RB        = bpra_pkg::ROW_BITS;
    localparam int SW        = bpra_pkg::ROW_SEL_W;

    bpra_pkg::state_t state_reg, state_next;

    logic [bpra_pkg::ADDR_W-1:0]  base_reg, base_next;
    logic [bpra_pkg::COUNT_W-1:0] pool_reg, pool_next;
    logic [LIM_W-1:0]             limit_reg, limit_next;
    logic [LIM_W-1:0]             count_reg, count_next;
    logic [LIM_W-1:0]             run_reg, run_next;
    logic [ROW_AW-1:0]            scan_row_reg, scan_row_next;
    logic [ROW_AW-1:0]            eval_row_reg, eval_row_next;
    logic                         eval_vld_reg, eval_vld_next;
    logic [PAGE_AW-1:0]           start_reg, start_next;
    logic [PAGE_AW-1:0]           end_reg, end_next;
    logic [ROW_AW-1:0]            mark_row_reg, mark_row_next;
    logic [ROW_AW-1:0]            clr_row_reg, clr_row_next;
    logic                         grant_reg, grant_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [bpra_pkg::ADDR_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                         m_tuser_reg, m_tuser_next;

    logic [RB-1:0]                map_mem [ROW_DEPTH];
    logic [RB-1:0]                rd_data_reg;
    logic [ROW_AW-1:0]            rd_addr;
    logic                         wr_en;
    logic [ROW_AW-1:0]            wr_addr;
    logic [RB-1:0]                wr_data;

    logic [bpra_pkg::COUNT_W-1:0] count_in;
    logic [31:0]                  pool_ext;
    logic [31:0]                  lim32;
    logic [31:0]                  count32;
    logic [LIM_W-1:0]             run_v;
    logic                         hit;
    logic [PAGE_AW-1:0]           hit_pos;
    logic [PAGE_AW-1:0]           pos_s;
    logic [PAGE_AW-1:0]           start_v;
    logic                         last_row;
    logic [RB-1:0]                mark_mask;
    logic [PAGE_AW-1:0]           pos_m;

    assign count_in = s_tdata[bpra_pkg::COUNT_W-1:0];
    assign pool_ext = {{(32 - bpra_pkg::COUNT_W){1'b0}}, pool_reg};
    assign lim32    = (pool_ext > 32'(MAX_PAGES)) ? 32'(MAX_PAGES) : pool_ext;
    assign count32  = {{(32 - bpra_pkg::COUNT_W){1'b0}}, count_in};

    // scan one map row: extend the current free run page by page
    always_comb begin
        run_v   = run_reg;
        hit     = 1'b0;
        hit_pos = '0;
        pos_s   = '0;
        for (int k = 0; k < RB; k++) begin
            pos_s = {eval_row_reg, SW'(k)};
            if (!hit && (LIM_W'(pos_s) < limit_reg)) begin
                if (rd_data_reg[k]) begin
                    run_v = '0;
                end else begin
                    run_v = run_v + LIM_W'(1);
                    if (run_v == count_reg) begin
                        hit     = 1'b1;
                        hit_pos = pos_s;
                    end
                end
            end
        end
        start_v  = PAGE_AW'(LIM_W'(hit_pos) + LIM_W'(1) - count_reg);
        last_row = (LIM_W'({eval_row_reg, {SW{1'b1}}}) + LIM_W'(1)) >= limit_reg;
    end

    always_comb begin
        pos_m = '0;
        for (int k = 0; k < RB; k++) begin
            pos_m        = {mark_row_reg, SW'(k)};
            mark_mask[k] = (pos_m >= start_reg) && (pos_m <= end_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bpra_pkg::ST_CLEAR;
            base_reg     <= bpra_pkg::BASE_RESET;
            pool_reg     <= bpra_pkg::POOL_RESET;
            clr_row_reg  <= '0;
            eval_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            base_reg     <= base_next;
            pool_reg     <= pool_next;
            clr_row_reg  <= clr_row_next;
            eval_vld_reg <= eval_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        limit_reg    <= limit_next;
        count_reg    <= count_next;
        run_reg      <= run_next;
        scan_row_reg <= scan_row_next;
        eval_row_reg <= eval_row_next;
        start_reg    <= start_next;
        end_reg      <= end_next;
        mark_row_reg <= mark_row_next;
        grant_reg    <= grant_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            map_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= map_mem[rd_addr];
    end

    always_comb begin
        state_next    = state_reg;
        base_next     = base_reg;
        pool_next     = pool_reg;
        limit_next    = limit_reg;
        count_next    = count_reg;
        run_next      = run_reg;
        scan_row_next = scan_row_reg;
        eval_row_next = eval_row_reg;
        eval_vld_next = eval_vld_reg;
        start_next    = start_reg;
        end_next      = end_reg;
        mark_row_next = mark_row_reg;
        clr_row_next  = clr_row_reg;
        grant_next    = grant_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        rd_addr       = scan_row_reg;
        wr_en         = 1'b0;
        wr_addr       = clr_row_reg;
        wr_data       = '0;
        s_tready      = 1'b0;

        if (cfg_wr_en) begin
            case (cfg_addr)
                bpra_pkg::CFG_BASE_ADDRESS: base_next = cfg_wr_data;
                bpra_pkg::CFG_POOL_PAGES:   pool_next = cfg_wr_data[bpra_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            bpra_pkg::ST_CLEAR: begin
                wr_en        = 1'b1;
                clr_row_next = clr_row_reg + ROW_AW'(1);
                if (&clr_row_reg) begin
                    state_next = bpra_pkg::ST_IDLE;
                end
            end
            bpra_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if ((count32 == 32'd0) || (count32 > lim32)) begin
                        grant_next = 1'b0;
                        state_next = bpra_pkg::ST_RESP;
                    end else begin
                        count_next    = LIM_W'(count32);
                        limit_next    = LIM_W'(lim32);
                        run_next      = '0;
                        scan_row_next = '0;
                        eval_vld_next = 1'b0;
                        state_next    = bpra_pkg::ST_SCAN;
                    end
                end
            end
            bpra_pkg::ST_SCAN: begin
                rd_addr       = scan_row_reg;
                scan_row_next = scan_row_reg + ROW_AW'(1);
                eval_row_next = scan_row_reg;
                eval_vld_next = 1'b1;
                if (eval_vld_reg) begin
                    run_next = run_v;
                    if (hit) begin
                        start_next    = start_v;
                        end_next      = hit_pos;
                        mark_row_next = start_v[PAGE_AW-1:SW];
                        eval_vld_next = 1'b0;
                        state_next    = bpra_pkg::ST_MARK_RD;
                    end else if (last_row) begin
                        grant_next    = 1'b0;
                        eval_vld_next = 1'b0;
                        state_next    = bpra_pkg::ST_RESP;
                    end
                end
            end
            bpra_pkg::ST_MARK_RD: begin
                rd_addr    = mark_row_reg;
                state_next = bpra_pkg::ST_MARK_WR;
            end
            bpra_pkg::ST_MARK_WR: begin
                wr_en   = 1'b1;
                wr_addr = mark_row_reg;
                wr_data = rd_data_reg | mark_mask;
                if (mark_row_reg == end_reg[PAGE_AW-1:SW]) begin
                    grant_next = 1'b1;
                    state_next = bpra_pkg::ST_RESP;
                end else begin
                    mark_row_next = mark_row_reg + ROW_AW'(1);
                    state_next    = bpra_pkg::ST_MARK_RD;
                end
            end
            bpra_pkg::ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = grant_reg;
                    m_tdata_next  = grant_reg
                                  ? base_reg + (32'(start_reg) << PAGE_SHIFT)
                                  : '0;
                    state_next    = bpra_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bpra_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tuser_reg) |-> (m_tdata_reg == '0))
        else $error("failed result carries a nonzero address");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while one is in work");

    a_hit_in_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bpra_pkg::ST_SCAN && eval_vld_reg && hit)
            |-> (LIM_W'(hit_pos) < limit_reg))
        else $error("run found beyond the pool");

    a_mark_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bpra_pkg::ST_MARK_WR)
            |-> (mark_row_reg >= start_reg[PAGE_AW-1:SW])
                && (mark_row_reg <= end_reg[PAGE_AW-1:SW]))
        else $error("mark outside the granted run");

    a_resp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> (m_tvalid_reg && $stable(m_tdata_reg)))
        else $error("pending result changed before it was taken");

endmodule

`default_nettype wire
